// File: hw/rtl/iida_pkg.sv
// Package for the indexed insert/delete array: sizes, op and status codes,
// cell command type and the control struct broadcast along the cell chain.
// No dependencies.
package iida_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int POS_W = 6;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_DELETE = 2'd3;

  localparam logic [2:0] STAT_OK     = 3'd0;
  localparam logic [2:0] STAT_FULL   = 3'd1;
  localparam logic [2:0] STAT_NEG    = 3'd2;
  localparam logic [2:0] STAT_EMPTY  = 3'd3;
  localparam logic [2:0] STAT_BEYOND = 3'd4;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  typedef struct packed {
    cell_cmd_t                  cmd;
    logic [IDX_W-1:0]           pos;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

// File: hw/rtl/iida_cell.sv
// One storage cell of the entry chain: holds one entry and takes from its
// lower or upper neighbor on insert, delete and rotate.
// Depends on iida_pkg.
module iida_cell (
  input  logic                             clk,
  input  iida_pkg::cell_ctl_t              ctl,
  input  logic [iida_pkg::IDX_W-1:0]       own_idx,
  input  logic signed [iida_pkg::DATA_W-1:0] prev_val,
  input  logic signed [iida_pkg::DATA_W-1:0] next_val,
  output logic signed [iida_pkg::DATA_W-1:0] val
);

  logic signed [iida_pkg::DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    case (ctl.cmd)
      iida_pkg::CMD_INS: begin
        if (own_idx > ctl.pos) begin
          val_next = prev_val;
        end else if (own_idx == ctl.pos) begin
          val_next = ctl.value;
        end
      end
      iida_pkg::CMD_DEL: begin
        if (own_idx >= ctl.pos) begin
          val_next = next_val;
        end
      end
      iida_pkg::CMD_ROT: val_next = next_val;
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

// File: hw/rtl/indexed_insert_delete_array.sv
// Top level of the indexed insert/delete array: control sequencer, entry
// cell chain and output register. Depends on iida_pkg and iida_cell.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  input   | in_valid, in_ready, op, position_in,      | in
//          | value_in                                  |
//  output  | out_valid, out_ready, status, value_out,  | out
//          | position_out, last                        |
//
// Clear resets the count and gives no output; an error or empty-list status
// is one output. Read and a successful insert or delete (not of the only
// entry) rotate the whole cell ring once, one step per cycle while the output
// is not stalled, emitting cell 0 on each of the first count steps.
// rst clears count, the sequencer and the output valid; entries are not reset.
// A stalled output holds the ring; non-emitting rotation steps never stall.
module indexed_insert_delete_array (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic signed [7:0]   position_in,
  input  logic signed [31:0]  value_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic signed [31:0]  value_out,
  output logic [5:0]          position_out,
  output logic                last
);

  iida_pkg::state_t     state, state_next;
  logic [iida_pkg::CNT_W-1:0] count, count_next;
  logic [iida_pkg::CNT_W-1:0] step, step_next;
  iida_pkg::cell_ctl_t  ctl;
  logic signed [iida_pkg::DATA_W-1:0] cell_val [iida_pkg::DEPTH];

  logic        out_free, acc, go_list, emit, adv, done;
  logic        load;
  logic [2:0]  ld_status;
  logic signed [31:0] ld_value;
  logic [5:0]  ld_pos;
  logic        ld_last;
  logic [7:0]  mag_ext, cnt_ext;

  assign out_free = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;
  assign mag_ext  = {1'b0, position_in[6:0]};
  assign cnt_ext  = 8'(count);
  assign emit     = step < count;
  assign adv      = !emit || out_free;
  assign done     = step == iida_pkg::CNT_W'(iida_pkg::DEPTH - 1);

  // Entry chain
  for (genvar i = 0; i < iida_pkg::DEPTH; i++) begin : g_cell
    logic signed [iida_pkg::DATA_W-1:0] prev_v, next_v;
    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = cell_val[i-1];
    end
    if (i == iida_pkg::DEPTH - 1) begin : g_last
      assign next_v = cell_val[0];
    end else begin : g_mid_n
      assign next_v = cell_val[i+1];
    end
    iida_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .own_idx  (iida_pkg::IDX_W'(i)),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_val[i])
    );
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      iida_pkg::ST_IDLE: if (go_list) state_next = iida_pkg::ST_LIST;
      iida_pkg::ST_LIST: if (adv && done) state_next = iida_pkg::ST_IDLE;
      default: state_next = iida_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready   = 1'b0;
    ctl.cmd    = iida_pkg::CMD_HOLD;
    ctl.pos    = '0;
    ctl.value  = value_in;
    load       = 1'b0;
    ld_status  = iida_pkg::STAT_OK;
    ld_value   = '0;
    ld_pos     = '0;
    ld_last    = 1'b1;
    count_next = count;
    step_next  = step;
    go_list    = 1'b0;
    case (state)
      iida_pkg::ST_IDLE: begin
        in_ready = out_free;
        if (acc) begin
          step_next = '0;
          case (op)
            iida_pkg::OP_CLEAR: count_next = '0;
            iida_pkg::OP_READ: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = iida_pkg::STAT_EMPTY;
              end else begin
                go_list = 1'b1;
              end
            end
            iida_pkg::OP_INSERT: begin
              if (count == iida_pkg::CNT_W'(iida_pkg::DEPTH)) begin
                load      = 1'b1;
                ld_status = iida_pkg::STAT_FULL;
              end else if (position_in[7]) begin
                load      = 1'b1;
                ld_status = iida_pkg::STAT_NEG;
              end else begin
                ctl.cmd    = iida_pkg::CMD_INS;
                ctl.pos    = (mag_ext > cnt_ext) ? iida_pkg::IDX_W'(count)
                                                 : iida_pkg::IDX_W'(mag_ext);
                count_next = count + 1'b1;
                go_list    = 1'b1;
              end
            end
            iida_pkg::OP_DELETE: begin
              if (count == '0) begin
                load      = 1'b1;
                ld_status = iida_pkg::STAT_EMPTY;
              end else if (position_in[7] || mag_ext >= cnt_ext) begin
                load      = 1'b1;
                ld_status = iida_pkg::STAT_BEYOND;
              end else begin
                ctl.cmd    = iida_pkg::CMD_DEL;
                ctl.pos    = iida_pkg::IDX_W'(mag_ext);
                count_next = count - 1'b1;
                // removing the only entry lists as an empty list
                if (count == iida_pkg::CNT_W'(1)) begin
                  load      = 1'b1;
                  ld_status = iida_pkg::STAT_EMPTY;
                end else begin
                  go_list = 1'b1;
                end
              end
            end
            default: count_next = count;
          endcase
        end
      end
      iida_pkg::ST_LIST: begin
        if (adv) begin
          ctl.cmd   = iida_pkg::CMD_ROT;
          step_next = step + 1'b1;
          if (emit) begin
            load      = 1'b1;
            ld_status = iida_pkg::STAT_OK;
            ld_value  = cell_val[0];
            ld_pos    = 6'(step);
            ld_last   = (step + 1'b1) == count;
          end
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iida_pkg::ST_IDLE;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= ld_status;
      value_out    <= ld_value;
      position_out <= ld_pos;
      last         <= ld_last;
    end
  end

endmodule
